/* hdl/c16k_pkg.sv */
// Shared constants, types and a helper function of the Code 16K code set decoder.
package c16k_pkg;

    typedef logic [1:0] set_t;

    localparam set_t SET_A    = 2'd0;
    localparam set_t SET_B    = 2'd1;
    localparam set_t SET_C    = 2'd2;
    localparam set_t SET_NONE = 2'd3;

    localparam logic [6:0] CW_FNC3    = 7'd96;
    localparam logic [6:0] CW_FNC2    = 7'd97;
    localparam logic [6:0] CW_SHIFT1  = 7'd98;
    localparam logic [6:0] CW_CODE_C  = 7'd99;
    localparam logic [6:0] CW_CODE_B  = 7'd100;
    localparam logic [6:0] CW_CODE_A  = 7'd101;
    localparam logic [6:0] CW_FNC1    = 7'd102;
    localparam logic [6:0] CW_PAD     = 7'd103;
    localparam logic [6:0] CW_SHIFT2  = 7'd104;
    localparam logic [6:0] CW_SHIFT2C = 7'd105;
    localparam logic [6:0] CW_SHIFT3C = 7'd106;

    localparam logic [6:0] CW_HIGH_A  = 7'd64;
    localparam logic [7:0] BYTE_GS    = 8'd29;
    localparam logic [7:0] HIGH_HALF  = 8'd128;
    localparam logic [7:0] ASCII_ZERO = 8'd48;

    localparam logic       CMD_START  = 1'b0;

    localparam logic [2:0] MODE_A     = 3'd0;
    localparam logic [2:0] MODE_B     = 3'd1;
    localparam logic [2:0] MODE_B_ALT = 3'd3;
    localparam logic [2:0] MODE_C_S1B = 3'd5;
    localparam logic [2:0] MODE_C_S2B = 3'd6;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_byte;
        logic       last_of_run;
        logic       reader_init;
        logic       decode_error;
    } result_t;

    // Tens digit of a value below 100 by reciprocal multiplication.
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] prod;
        prod = {8'b0, v} * 15'd205;
        return prod[14:11];
    endfunction

endpackage

/* hdl/c16k_step.sv */
// Code set state registers and the decode of one transaction into one or two results.
module c16k_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  logic               command,
    input  logic [2:0]         start_mode,
    input  logic [6:0]         codeword,
    output c16k_pkg::result_t  first_res,
    output c16k_pkg::result_t  second_res,
    output logic               two_res
);
    import c16k_pkg::*;

    set_t       code_set_reg, code_set_next;
    logic [1:0] shift_cnt_reg, shift_cnt_next;
    set_t       ret_set_reg, ret_set_next;
    logic       latched_reg, latched_next;
    logic       pending_reg, pending_next;
    logic       init_reg, init_next;
    logic       err_reg, err_next;

    logic [3:0] tens;
    logic [6:0] ones;

    assign tens = tens_of(codeword);
    assign ones = codeword - ({3'b0, tens} * 7'd10);

    always_comb
    begin
        logic       has_byte;
        logic [7:0] byte_val;
        logic       ext;
        logic       do_shift;
        logic [1:0] shift_n;
        set_t       shift_dst;
        logic       digits;

        code_set_next  = code_set_reg;
        shift_cnt_next = shift_cnt_reg;
        ret_set_next   = ret_set_reg;
        latched_next   = latched_reg;
        pending_next   = pending_reg;
        init_next      = init_reg;
        err_next       = err_reg;
        has_byte       = 1'b0;
        byte_val       = 8'd0;
        ext            = latched_reg ^ pending_reg;
        do_shift       = 1'b0;
        shift_n        = 2'd0;
        shift_dst      = SET_B;
        digits         = 1'b0;

        if (command == CMD_START)
        begin
            shift_cnt_next = 2'd0;
            ret_set_next   = SET_NONE;
            latched_next   = 1'b0;
            pending_next   = 1'b0;
            init_next      = 1'b0;
            err_next       = 1'b0;
            if (start_mode == MODE_A)
                code_set_next = SET_A;
            else if (start_mode == MODE_B || start_mode == MODE_B_ALT)
                code_set_next = SET_B;
            else
                code_set_next = SET_C;
            if (start_mode == MODE_C_S1B || start_mode == MODE_C_S2B)
            begin
                shift_cnt_next = 2'(start_mode - 3'd4);
                ret_set_next   = SET_C;
                code_set_next  = SET_B;
            end
        end
        else
        begin
            if (ret_set_next != SET_NONE)
            begin
                if (shift_cnt_next == 2'd0)
                begin
                    code_set_next = ret_set_next;
                    ret_set_next  = SET_NONE;
                end
                else
                begin
                    shift_cnt_next = shift_cnt_next - 2'd1;
                end
            end

            if (codeword > CW_SHIFT3C)
            begin
                has_byte = 1'b0;
            end
            else if (code_set_next == SET_C)
            begin
                if (codeword < CW_CODE_B)
                    digits = 1'b1;
                else if (codeword == CW_CODE_A)
                    code_set_next = SET_A;
                else if (codeword == CW_CODE_B)
                    code_set_next = SET_B;
                else if (codeword == CW_FNC1)
                begin
                    has_byte = 1'b1;
                    byte_val = BYTE_GS;
                end
                else if (codeword >= CW_SHIFT2)
                begin
                    do_shift  = 1'b1;
                    shift_n   = 2'(codeword - CW_SHIFT2 + 7'd1);
                    shift_dst = SET_B;
                end
            end
            else
            begin
                if (codeword == CW_FNC1)
                begin
                    has_byte = 1'b1;
                    byte_val = BYTE_GS;
                end
                else if (codeword == CW_FNC2 || codeword == CW_PAD)
                begin
                    has_byte = 1'b0;
                end
                else if (codeword == CW_FNC3)
                begin
                    init_next = 1'b1;
                end
                else if (codeword == CW_CODE_A || codeword == CW_CODE_B)
                begin
                    if ((codeword == CW_CODE_A) == (code_set_next == SET_A))
                    begin
                        if (pending_reg)
                            latched_next = ~latched_reg;
                        pending_next = ~pending_reg;
                    end
                    else
                    begin
                        code_set_next = (codeword == CW_CODE_A) ? SET_A : SET_B;
                    end
                end
                else if (codeword == CW_CODE_C)
                begin
                    code_set_next = SET_C;
                end
                else if (codeword == CW_SHIFT1 || codeword == CW_SHIFT2)
                begin
                    do_shift  = 1'b1;
                    shift_n   = (codeword == CW_SHIFT1) ? 2'd1 : 2'd2;
                    shift_dst = (code_set_next == SET_A) ? SET_B : SET_A;
                end
                else if (codeword == CW_SHIFT2C || codeword == CW_SHIFT3C)
                begin
                    do_shift  = 1'b1;
                    shift_n   = 2'(codeword - CW_SHIFT2C + 7'd2);
                    shift_dst = SET_C;
                end
                else
                begin
                    if (code_set_next == SET_A && codeword >= CW_HIGH_A)
                        byte_val = ext ? ({1'b0, codeword} + 8'd64)
                                       : ({1'b0, codeword} - 8'd64);
                    else
                        byte_val = {1'b0, codeword} + 8'd32 + (ext ? HIGH_HALF : 8'd0);
                    has_byte     = 1'b1;
                    pending_next = 1'b0;
                end
            end

            if (do_shift)
            begin
                if (ret_set_next != SET_NONE)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    shift_cnt_next = shift_n;
                    ret_set_next   = code_set_next;
                    code_set_next  = shift_dst;
                end
            end
        end

        two_res = digits;

        first_res.reader_init  = init_next;
        first_res.decode_error = err_next;
        second_res.reader_init  = init_next;
        second_res.decode_error = err_next;
        second_res.char_valid   = 1'b1;
        second_res.char_byte    = ASCII_ZERO + {1'b0, ones};
        second_res.last_of_run  = 1'b1;
        if (digits)
        begin
            first_res.char_valid  = 1'b1;
            first_res.char_byte   = ASCII_ZERO + {4'b0, tens};
            first_res.last_of_run = 1'b0;
        end
        else
        begin
            first_res.char_valid  = has_byte;
            first_res.char_byte   = byte_val;
            first_res.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_set_reg  <= SET_A;
            shift_cnt_reg <= 2'd0;
            ret_set_reg   <= SET_NONE;
            latched_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            init_reg      <= 1'b0;
            err_reg       <= 1'b0;
        end
        else if (commit)
        begin
            code_set_reg  <= code_set_next;
            shift_cnt_reg <= shift_cnt_next;
            ret_set_reg   <= ret_set_next;
            latched_reg   <= latched_next;
            pending_reg   <= pending_next;
            init_reg      <= init_next;
            err_reg       <= err_next;
        end
    end

endmodule

/* hdl/code16k_codeset_decoder.sv */
// Top level of the Code 16K code set decoder: input register, decode step and output stage.
//
// Channel  Dir  tdata bits (low to high)                 tuser         tlast
// s_axis   in   start_mode[2:0], codeword[9:3], zero pad  command       -
// m_axis   out  char_byte[7:0], reader_init, decode_error char_valid    last_of_run
//
// A transaction is registered on entry and then decoded from the input register into the
// output register, from which the first result is presented.
// Most codewords give one result each; a set C digit pair gives two because its
// second digit waits in a holding register for the single output register.
// Reset clears the code set state to set A with no shift and empties all stages.
// A stall on m_axis holds the output register and backs up into the input register.
module code16k_codeset_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // start_mode, codeword, zero pad
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // char_byte, reader_init, decode_error, zero pad
    output logic        m_axis_tuser,   // char_valid
    output logic        m_axis_tlast
);
    import c16k_pkg::*;

    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [2:0] in_mode_reg;
    logic [6:0] in_cw_reg;

    logic       out_valid_reg;
    result_t    out_reg;
    logic       pend_valid_reg;
    result_t    pend_reg;

    result_t    first_res;
    result_t    second_res;
    logic       two_res;
    logic       out_open;
    logic       advance;

    assign out_open      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_open && !pend_valid_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    c16k_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (advance),
        .command    (in_cmd_reg),
        .start_mode (in_mode_reg),
        .codeword   (in_cw_reg),
        .first_res  (first_res),
        .second_res (second_res),
        .two_res    (two_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_open && pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= two_res;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_mode_reg <= s_axis_tdata[2:0];
            in_cw_reg   <= s_axis_tdata[9:3];
        end
        if (out_open && pend_valid_reg)
            out_reg <= pend_reg;
        else if (advance)
        begin
            out_reg  <= first_res;
            pend_reg <= second_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.decode_error, out_reg.reader_init, out_reg.char_byte};
    assign m_axis_tuser  = out_reg.char_valid;
    assign m_axis_tlast  = out_reg.last_of_run;

endmodule

/* test/code16k_codeset_decoder_test.sv */
// Self-checking testbench of the Code 16K code set decoder: directed and random codeword streams.
module code16k_codeset_decoder_test;
    import c16k_pkg::*;

    localparam logic       CMD_DATA     = 1'b1;
    localparam logic [2:0] MODE_C_ALT   = 3'd4;
    localparam logic [2:0] MODE_C_PLAIN = 3'd7;
    localparam int         IDLE_PCT     = 17;
    localparam int         RANDOM_ITEMS = 1120;
    localparam int         N_DIRECTED   = 30;

    typedef struct packed {
        logic       cmd;
        logic [2:0] mode;
        logic [6:0] cw;
        logic [1:0] typed;
        result_t    t0;
        result_t    t1;
    } stim_row_t;

    localparam result_t NONE = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    set_t       cur_set;
    logic [1:0] shift_left;
    set_t       return_set;
    logic       fnc4_latch;
    logic       fnc4_next;
    logic       init_flag;
    logic       error_flag;

    result_t expected_chars[$];
    int      mismatches = 0;
    logic    no_gaps = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{CMD_START, MODE_A, 7'd0, 2'd1, '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0}, NONE},
        '{CMD_DATA, MODE_A, 7'd0, 2'd1, '{1'b1, 8'd32, 1'b1, 1'b0, 1'b0}, NONE},
        '{CMD_DATA, MODE_A, 7'd95, 2'd1, '{1'b1, 8'd31, 1'b1, 1'b0, 1'b0}, NONE},
        '{CMD_DATA, MODE_A, 7'd127, 2'd1, '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0}, NONE},
        '{CMD_DATA, MODE_A, CW_FNC1, 2'd1, '{1'b1, BYTE_GS, 1'b1, 1'b0, 1'b0}, NONE},
        '{CMD_DATA, MODE_A, CW_FNC3, 2'd1, '{1'b0, 8'd0, 1'b1, 1'b1, 1'b0}, NONE},
        '{CMD_DATA, MODE_A, CW_CODE_A, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, 7'd65, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, CW_CODE_A, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, CW_CODE_A, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, 7'd10, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, CW_SHIFT1, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, CW_SHIFT1, 2'd1, '{1'b0, 8'd0, 1'b1, 1'b1, 1'b1}, NONE},
        '{CMD_DATA, MODE_A, CW_CODE_C, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, 7'd0, 2'd2, '{1'b1, ASCII_ZERO, 1'b0, 1'b1, 1'b1},
            '{1'b1, ASCII_ZERO, 1'b1, 1'b1, 1'b1}},
        '{CMD_DATA, MODE_A, 7'd99, 2'd2, '{1'b1, ASCII_ZERO + 8'd9, 1'b0, 1'b1, 1'b1},
            '{1'b1, ASCII_ZERO + 8'd9, 1'b1, 1'b1, 1'b1}},
        '{CMD_DATA, MODE_A, CW_SHIFT3C, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, CW_FNC2, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, CW_PAD, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, 7'd50, 2'd0, NONE, NONE},
        '{CMD_START, MODE_C_PLAIN, 7'd127, 2'd1, '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0}, NONE},
        '{CMD_DATA, MODE_A, CW_SHIFT2C, 2'd0, NONE, NONE},
        '{CMD_START, MODE_C_S1B, 7'd0, 2'd1, '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0}, NONE},
        '{CMD_DATA, MODE_A, 7'd33, 2'd0, NONE, NONE},
        '{CMD_START, MODE_C_S2B, 7'd0, 2'd0, NONE, NONE},
        '{CMD_START, MODE_B, 7'd0, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, CW_CODE_B, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_A, 7'd95, 2'd0, NONE, NONE},
        '{CMD_START, MODE_B_ALT, 7'd0, 2'd0, NONE, NONE},
        '{CMD_DATA, MODE_C_ALT, CW_SHIFT2, 2'd0, NONE, NONE}
    };

    code16k_codeset_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t char_result(logic valid, logic [7:0] value, logic last);
        return '{valid, value, last, init_flag, error_flag};
    endfunction

    function automatic void begin_shift(logic [1:0] count, set_t dst);
        if (return_set != SET_NONE)
        begin
            error_flag = 1'b1;
            return;
        end
        shift_left = count;
        return_set = cur_set;
        cur_set = dst;
    endfunction

    function automatic void decode_item(input logic cmd, input logic [2:0] mode,
                                        input logic [6:0] cw, output int n,
                                        output result_t r0, output result_t r1);
        logic       has_char;
        logic [7:0] value;
        logic [6:0] own_latch;
        logic       ext;
        has_char = 1'b0;
        value = '0;
        r1 = NONE;
        n = 1;
        if (cmd == CMD_START)
        begin
            shift_left = '0;
            return_set = SET_NONE;
            fnc4_latch = 1'b0;
            fnc4_next = 1'b0;
            init_flag = 1'b0;
            error_flag = 1'b0;
            if (mode == MODE_A)
                cur_set = SET_A;
            else if (mode == MODE_B || mode == MODE_B_ALT)
                cur_set = SET_B;
            else
                cur_set = SET_C;
            if (mode == MODE_C_S1B || mode == MODE_C_S2B)
            begin
                shift_left = (mode == MODE_C_S1B) ? 2'd1 : 2'd2;
                return_set = SET_C;
                cur_set = SET_B;
            end
            r0 = char_result(1'b0, '0, 1'b1);
            return;
        end
        if (return_set != SET_NONE)
        begin
            if (shift_left == 2'd0)
            begin
                cur_set = return_set;
                return_set = SET_NONE;
            end
            else
                shift_left = shift_left - 2'd1;
        end
        if (cw > CW_SHIFT3C)
            ;
        else if (cur_set == SET_C)
        begin
            if (cw < CW_CODE_B)
            begin
                n = 2;
                r0 = char_result(1'b1, ASCII_ZERO + 8'(cw / 10), 1'b0);
                r1 = char_result(1'b1, ASCII_ZERO + 8'(cw % 10), 1'b1);
                return;
            end
            else if (cw == CW_CODE_A)
                cur_set = SET_A;
            else if (cw == CW_CODE_B)
                cur_set = SET_B;
            else if (cw == CW_FNC1)
            begin
                has_char = 1'b1;
                value = BYTE_GS;
            end
            else if (cw >= CW_SHIFT2)
                begin_shift(2'(cw - CW_SHIFT2 + 7'd1), SET_B);
        end
        else
        begin
            own_latch = (cur_set == SET_A) ? CW_CODE_A : CW_CODE_B;
            case (cw)
                CW_FNC1:
                begin
                    has_char = 1'b1;
                    value = BYTE_GS;
                end
                CW_FNC2, CW_PAD:
                    ;
                CW_FNC3:
                    init_flag = 1'b1;
                CW_CODE_A, CW_CODE_B:
                begin
                    if (cw == own_latch)
                    begin
                        if (fnc4_next)
                            fnc4_latch = ~fnc4_latch;
                        fnc4_next = ~fnc4_next;
                    end
                    else
                        cur_set = (cw == CW_CODE_A) ? SET_A : SET_B;
                end
                CW_CODE_C:
                    cur_set = SET_C;
                CW_SHIFT1, CW_SHIFT2:
                    begin_shift((cw == CW_SHIFT1) ? 2'd1 : 2'd2,
                                (cur_set == SET_A) ? SET_B : SET_A);
                CW_SHIFT2C, CW_SHIFT3C:
                    begin_shift(2'(cw - CW_SHIFT2C + 7'd2), SET_C);
                default:
                begin
                    ext = fnc4_latch != fnc4_next;
                    if (cur_set == SET_A && cw >= CW_HIGH_A)
                        value = ext ? {1'b0, cw} + 8'd64 : {1'b0, cw} - 8'd64;
                    else
                        value = {1'b0, cw} + 8'd32 + (ext ? HIGH_HALF : 8'd0);
                    has_char = 1'b1;
                    fnc4_next = 1'b0;
                end
            endcase
        end
        r0 = char_result(has_char, value, 1'b1);
    endfunction

    task automatic send_item(input logic cmd, input logic [2:0] mode, input logic [6:0] cw,
                             input logic [1:0] typed, input result_t t0, input result_t t1);
        int      n;
        result_t r0;
        result_t r1;
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'b0, cw, mode};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_item(cmd, mode, cw, n, r0, r1);
        if (typed != 2'd0)
        begin
            n = typed;
            r0 = t0;
            r1 = t1;
        end
        expected_chars = {expected_chars, r0};
        if (n == 2)
            expected_chars = {expected_chars, r1};
    endtask

    function automatic logic [6:0] random_codeword();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return 7'($urandom_range(95));
        else if (pick < 88)
            return 7'($urandom_range(CW_SHIFT3C, CW_FNC3));
        else if (pick < 95)
            return 7'($urandom_range(127));
        return 7'($urandom_range(127, 107));
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected transaction: char_byte %0d", m_axis_tdata[7:0]);
                mismatches++;
            end
            else
            begin
                want = expected_chars.pop_front();
                check_field("char_valid", want.char_valid, m_axis_tuser);
                check_field("char_byte", want.char_byte, m_axis_tdata[7:0]);
                check_field("last_of_run", want.last_of_run, m_axis_tlast);
                check_field("reader_init", want.reader_init, m_axis_tdata[8]);
                check_field("decode_error", want.decode_error, m_axis_tdata[9]);
            end
        end
        m_axis_tready <= rst_n && (no_gaps || $urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin
        #4000000;
        $display("[code16k_codeset_decoder] ERROR");
        $finish;
    end

    initial
    begin
        int         counted;
        logic       cmd;
        logic [6:0] cw;
        cur_set = SET_A;
        shift_left = '0;
        return_set = SET_NONE;
        fnc4_latch = 1'b0;
        fnc4_next = 1'b0;
        init_flag = 1'b0;
        error_flag = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].mode, directed_rows[i].cw,
                      directed_rows[i].typed, directed_rows[i].t0, directed_rows[i].t1);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            no_gaps = counted >= 400 && counted < 600;
            if (counted == 800)
            begin
                s_axis_tvalid <= 1'b0;
                while (expected_chars.size() != 0)
                    @(posedge clk);
            end
            cmd = ($urandom_range(99) < 4) ? CMD_START : CMD_DATA;
            cw = random_codeword();
            send_item(cmd, 3'($urandom_range(7)), cw, 2'd0, NONE, NONE);
            counted++;
        end
        s_axis_tvalid <= 1'b0;
        no_gaps = 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[code16k_codeset_decoder] OK");
        else
            $display("[code16k_codeset_decoder] ERROR");
        $finish;
    end

endmodule
